>>> rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that cond never holds at a rising clk edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> rtl/hec_pkg.sv
// Types, code tables and helper functions for the Hamming encode/check core.
package hec_pkg;

	localparam int NUM_CODES  = 5;
	localparam int MAX_DATA   = 12;
	localparam int WORD_W     = 17;
	localparam int SYN_W      = 5;
	localparam int CFG_W      = 3;
	localparam int CODE_IDX_W = $clog2(NUM_CODES);

	typedef enum logic {
		OP_ENCODE = 1'b0,
		OP_CHECK  = 1'b1
	} hec_op_t;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [SYN_W-1:0]  syndrome;
		logic              parity_ok;
	} hec_result_t;

	localparam int BLK_LEN [NUM_CODES] = '{7, 13, 15, 16, 17};
	localparam int MSG_LEN [NUM_CODES] = '{4, 9, 11, 11, 12};

	localparam logic [SYN_W-1:0] GEN_ROWS [NUM_CODES][MAX_DATA] = '{
		'{5'h05, 5'h07, 5'h06, 5'h03, 5'h00, 5'h00,
		  5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
		'{5'h0f, 5'h0e, 5'h07, 5'h0a, 5'h05, 5'h0b,
		  5'h0c, 5'h06, 5'h03, 5'h00, 5'h00, 5'h00},
		'{5'h09, 5'h0d, 5'h0f, 5'h0e, 5'h07, 5'h0a,
		  5'h05, 5'h0b, 5'h0c, 5'h06, 5'h03, 5'h00},
		'{5'h13, 5'h1a, 5'h1f, 5'h1c, 5'h0e, 5'h15,
		  5'h0b, 5'h16, 5'h19, 5'h0d, 5'h07, 5'h00},
		'{5'h1b, 5'h1f, 5'h1d, 5'h1c, 5'h0e, 5'h07,
		  5'h11, 5'h1a, 5'h0d, 5'h14, 5'h0a, 5'h05}
	};

	// Data bits that feed parity bit x of code c.
	function automatic logic [MAX_DATA-1:0] par_mask(int c, int x);
		logic [MAX_DATA-1:0] m;
		int b;
		m = '0;
		b = BLK_LEN[c] - MSG_LEN[c];
		for (int y = 0; y < MAX_DATA; y++) begin
			if ((y < MSG_LEN[c]) && (x < b)) begin
				m[y] = GEN_ROWS[c][y][b - x - 1];
			end
		end
		return m;
	endfunction

	// Map unused selector codes onto the last code.
	function automatic logic [CODE_IDX_W-1:0] sat_sel(logic [CFG_W-1:0] v);
		logic [CODE_IDX_W-1:0] r;
		if (v > CFG_W'(NUM_CODES - 1)) begin
			r = CODE_IDX_W'(NUM_CODES - 1);
		end else begin
			r = v[CODE_IDX_W-1:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/hec_parity.sv
// Parity network: encode or check one word for the selected code.
module hec_parity import hec_pkg::*; (
	input  logic [CODE_IDX_W-1:0] sel,
	input  hec_op_t               op,
	input  logic [WORD_W-1:0]     word,
	output hec_result_t           res
);

	logic [WORD_W-1:0] enc_word [NUM_CODES];
	logic [WORD_W-1:0] chk_word [NUM_CODES];
	logic [SYN_W-1:0]  chk_syn  [NUM_CODES];

	for (genvar c = 0; c < NUM_CODES; c++) begin : g_code
		localparam int N = BLK_LEN[c];
		localparam int K = MSG_LEN[c];
		localparam int B = N - K;

		logic [B-1:0] par;

		for (genvar x = 0; x < B; x++) begin : g_par
			localparam logic [MAX_DATA-1:0] MASK = par_mask(c, x);
			assign par[x] = ^(word[K-1:0] & MASK[K-1:0]);
		end

		assign enc_word[c] = WORD_W'({par, word[K-1:0]});
		assign chk_word[c] = WORD_W'(word[N-1:0]);
		assign chk_syn[c]  = SYN_W'(word[N-1:K] ^ par);
	end

	always_comb begin
		if (op == OP_ENCODE) begin
			res.word      = enc_word[sel];
			res.syndrome  = '0;
			res.parity_ok = 1'b1;
		end else begin
			res.word      = chk_word[sel];
			res.syndrome  = chk_syn[sel];
			res.parity_ok = (chk_syn[sel] == '0);
		end
	end

endmodule

>>> rtl/hamming_encode_check_core.sv
// Top level: Hamming (n,k) encoder and parity checker with selectable code.
// An accepted transaction passes through the input register and then the result register
// before its result shows with done high.
// Throughput: one transaction per cycle; busy is always low and results cannot be held off.
// Reset: arst_n clears the code selector to the (7,4,3) code and drops all valid flags.
`include "assert_macros.svh"

module hamming_encode_check_core import hec_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [CFG_W-1:0]  cfg_wr_data,
	input  logic              start,
	output logic              busy,
	input  logic              opcode,
	input  logic [WORD_W-1:0] word_in,
	output logic              done,
	output logic [WORD_W-1:0] word_out,
	output logic [SYN_W-1:0]  syndrome,
	output logic              parity_ok
);

	logic [CODE_IDX_W-1:0] code_sel_q;
	logic                  vld_s1;
	hec_op_t               op_s1;
	logic [WORD_W-1:0]     word_s1;
	logic [CODE_IDX_W-1:0] sel_s1;
	hec_result_t           res_comb;
	hec_result_t           res_s2;
	logic                  vld_s2;
	logic                  accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_sel_q <= '0;
		end else if (cfg_wr_en) begin
			code_sel_q <= sat_sel(cfg_wr_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= hec_op_t'(opcode);
			word_s1 <= word_in;
			sel_s1  <= code_sel_q;
		end
		if (vld_s1) begin
			res_s2 <= res_comb;
		end
	end

	hec_parity u_parity (
		.sel  (sel_s1),
		.op   (op_s1),
		.word (word_s1),
		.res  (res_comb)
	);

	assign done      = vld_s2;
	assign word_out  = res_s2.word;
	assign syndrome  = res_s2.syndrome;
	assign parity_ok = res_s2.parity_ok;

	`ASSERT_CLK(a_accept_to_done, accept |-> ##2 done, "accepted transaction produced no result")
	`ASSERT_CLK(a_ok_matches_syn, done |-> (parity_ok == (syndrome == '0)),
		"parity_ok disagrees with syndrome")
	`ASSERT_CLK(a_encode_clean, (vld_s1 && (op_s1 == OP_ENCODE)) |=> (syndrome == '0 && parity_ok),
		"encode result carries a nonzero syndrome")
	`ASSERT_NEVER(a_sel_range, code_sel_q > CODE_IDX_W'(NUM_CODES - 1),
		"code selector outside the code table")

endmodule
